@@ rtl/core/rslp_pkg.sv @@
// ----------------------------------------------------------------------------
// rslp_pkg: shared types and constants
// Payload structs for the character and result channels, the classified queue
// entry that passes from front to back, and the radix kind codes.
// ----------------------------------------------------------------------------
package rslp_pkg;

  localparam int VALUE_W = 64;
  localparam int CONS_W  = 9;
  localparam int N_ALT   = 4;
  localparam int Q_DEPTH = 2;

  // Alternative index doubles as the reported radix kind; lower index wins.
  localparam logic [1:0] RK_HEX = 2'd0;
  localparam logic [1:0] RK_OCT = 2'd1;
  localparam logic [1:0] RK_BIN = 2'd2;
  localparam logic [1:0] RK_DEC = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
    logic [1:0]         radix_kind;
    logic [CONS_W-1:0]  consumed;
    logic               overflow;
    logic               overlong;
  } result_t;

  // One character after classification.
  typedef struct packed {
    logic [3:0]       digit;    // digit value, meaningful where dig_ok is set
    logic [N_ALT-1:0] dig_ok;   // digit in the radix of each alternative
    logic [N_ALT-1:0] sfx;      // suffix letter of each alternative
    logic             us;       // underscore
    logic             feed;     // within the length limit
    logic             last;
    logic             too_long; // string has run past the limit (valid with last)
  } qent_t;

endpackage

@@ rtl/core/rslp_stream_if.sv @@
// ----------------------------------------------------------------------------
// rslp_stream_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface rslp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rslp_front.sv @@
// ----------------------------------------------------------------------------
// rslp_front: character classifier
// Tracks string position against the length limit and tags each character
// with its digit value and class bits for every alternative.
// ----------------------------------------------------------------------------
module rslp_front import rslp_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  logic          clk,
  input  logic          rst,
  rslp_stream_if.sink   chars,
  output qent_t         ent,
  output logic          ent_valid,
  input  logic          ent_ready
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  logic [LEN_W-1:0] position;
  logic             too_long;
  logic             feed;
  logic [7:0]       c;
  logic [7:0]       off;

  assign c         = chars.data.ch;
  assign feed      = position < LEN_W'(MAX_LEN);
  assign ent_valid = chars.valid;
  assign chars.ready = ent_ready;

  always_comb begin
    ent          = '0;
    off          = 8'h00;
    ent.feed     = feed;
    ent.last     = chars.data.last;
    ent.too_long = too_long | ~feed;
    case (c) inside
      [8'h30:8'h39]: begin // 0-9
        off              = c - 8'h30;
        ent.dig_ok[RK_HEX] = 1'b1;
        ent.dig_ok[RK_DEC] = 1'b1;
        ent.dig_ok[RK_OCT] = (off < 8'd8);
        ent.dig_ok[RK_BIN] = (off < 8'd2);
      end
      [8'h61:8'h66]: begin // a-f
        off                = c - 8'h57;
        ent.dig_ok[RK_HEX] = 1'b1;
      end
      [8'h41:8'h46]: begin // A-F
        off                = c - 8'h37;
        ent.dig_ok[RK_HEX] = 1'b1;
      end
      8'h5F:   ent.us = 1'b1;
      default: ;
    endcase
    ent.digit       = off[3:0];
    ent.sfx[RK_HEX] = (c == 8'h68) || (c == 8'h48) || (c == 8'h78) || (c == 8'h58);
    ent.sfx[RK_OCT] = (c == 8'h71) || (c == 8'h51) || (c == 8'h6F) || (c == 8'h4F);
    ent.sfx[RK_BIN] = (c == 8'h62) || (c == 8'h42) || (c == 8'h79) || (c == 8'h59);
    ent.sfx[RK_DEC] = (c == 8'h64) || (c == 8'h44) || (c == 8'h74) || (c == 8'h54);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      too_long <= 1'b0;
    end else if (chars.valid && ent_ready) begin
      if (chars.data.last) begin
        position <= '0;
        too_long <= 1'b0;
      end else if (!feed) begin
        too_long <= 1'b1;
      end else begin
        position <= position + 1'b1;
      end
    end
  end

  a_too_long_at_limit: assert property (@(posedge clk) disable iff (rst)
    too_long |-> (position == LEN_W'(MAX_LEN)))
    else $error("too_long set below the length limit");

endmodule

@@ rtl/core/rslp_queue.sv @@
// ----------------------------------------------------------------------------
// rslp_queue: short FIFO between classifier and accumulators
// Lets front and back stall independently; full throughput at depth two.
// ----------------------------------------------------------------------------
module rslp_queue import rslp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  qent_t wr_data,
  input  logic  wr_valid,
  output logic  wr_ready,
  output qent_t rd_data,
  output logic  rd_valid,
  input  logic  rd_ready
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  qent_t            mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = count < CNT_W'(Q_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ rtl/core/rslp_back.sv @@
// ----------------------------------------------------------------------------
// rslp_back: accumulators and result register
// Four alternatives advance side by side, one classified character a cycle;
// on the last, once the result slot is free, the winner is picked and registered.
// ----------------------------------------------------------------------------
module rslp_back import rslp_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  qent_t         ent,
  input  logic          ent_valid,
  output logic          ent_ready,
  rslp_stream_if.source results
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {PH_COLLECT, PH_MATCHED, PH_FAILED} phase_t;

  phase_t             phase      [N_ALT];
  phase_t             phase_next [N_ALT];
  logic [VALUE_W-1:0] acc        [N_ALT];
  logic [VALUE_W-1:0] acc_next   [N_ALT];
  logic               ovf        [N_ALT];
  logic               ovf_next   [N_ALT];
  logic [LEN_W-1:0]   len        [N_ALT];
  logic [LEN_W-1:0]   len_next   [N_ALT];

  logic [VALUE_W-1:0] prod [N_ALT];
  logic               povf [N_ALT];
  logic [VALUE_W+3:0] dec_sum;

  logic    out_valid;
  result_t out_data;
  result_t res_next;
  logic    pop;
  logic    win_any;
  logic [1:0] win;

  assign results.valid = out_valid;
  assign results.data  = out_data;
  // Last character needs a free result slot; others always drain.
  assign ent_ready = !ent.last || !out_valid || results.ready;
  assign pop       = ent_valid && ent_ready;

  // Shift-and-add per radix; overflow when the product leaves 64 bits.
  assign prod[RK_HEX] = {acc[RK_HEX][VALUE_W-5:0], ent.digit};
  assign povf[RK_HEX] = acc[RK_HEX][VALUE_W-1:VALUE_W-4] != '0;
  assign prod[RK_OCT] = {acc[RK_OCT][VALUE_W-4:0], ent.digit[2:0]};
  assign povf[RK_OCT] = acc[RK_OCT][VALUE_W-1:VALUE_W-3] != '0;
  assign prod[RK_BIN] = {acc[RK_BIN][VALUE_W-2:0], ent.digit[0]};
  assign povf[RK_BIN] = acc[RK_BIN][VALUE_W-1];
  assign dec_sum      = {1'b0, acc[RK_DEC], 3'b000} + {3'b000, acc[RK_DEC], 1'b0}
                      + {64'd0, ent.digit};
  assign prod[RK_DEC] = dec_sum[VALUE_W-1:0];
  assign povf[RK_DEC] = dec_sum[VALUE_W+3:VALUE_W] != '0;

  always_comb begin
    for (int a = 0; a < N_ALT; a++) begin
      phase_next[a] = phase[a];
      acc_next[a]   = acc[a];
      ovf_next[a]   = ovf[a];
      len_next[a]   = len[a];
      if (ent.feed && phase[a] == PH_COLLECT) begin
        if (ent.us) begin
          len_next[a] = len[a] + 1'b1;
        end else if (ent.dig_ok[a]) begin
          len_next[a] = len[a] + 1'b1;
          if (ovf[a] || povf[a]) begin
            ovf_next[a] = 1'b1;
            acc_next[a] = '1;
          end else begin
            acc_next[a] = prod[a];
          end
        end else if (len[a] == '0) begin
          phase_next[a] = PH_FAILED;
        end else if (ent.sfx[a]) begin
          len_next[a]   = len[a] + 1'b1;
          phase_next[a] = PH_MATCHED;
        end else if (a == int'(RK_DEC)) begin
          phase_next[a] = PH_MATCHED; // decimal suffix is optional
        end else begin
          phase_next[a] = PH_FAILED;
        end
      end
    end
  end

  // Winner in priority order; an open decimal run closes at end of string.
  always_comb begin
    win_any = 1'b1;
    win     = RK_HEX;
    if (phase_next[RK_HEX] == PH_MATCHED) begin
      win = RK_HEX;
    end else if (phase_next[RK_OCT] == PH_MATCHED) begin
      win = RK_OCT;
    end else if (phase_next[RK_BIN] == PH_MATCHED) begin
      win = RK_BIN;
    end else if (phase_next[RK_DEC] == PH_MATCHED ||
                 (phase_next[RK_DEC] == PH_COLLECT && len_next[RK_DEC] != '0)) begin
      win = RK_DEC;
    end else begin
      win_any = 1'b0;
    end
    res_next          = '0;
    res_next.overlong = ent.too_long;
    if (!ent.too_long && win_any) begin
      res_next.ok         = 1'b1;
      res_next.value      = acc_next[win];
      res_next.radix_kind = win;
      res_next.consumed   = CONS_W'(len_next[win]);
      res_next.overflow   = ovf_next[win];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int a = 0; a < N_ALT; a++) begin
        phase[a] <= PH_COLLECT;
        acc[a]   <= '0;
        ovf[a]   <= 1'b0;
        len[a]   <= '0;
      end
    end else begin
      if (pop && ent.last) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        for (int a = 0; a < N_ALT; a++) begin
          if (ent.last) begin
            phase[a] <= PH_COLLECT;
            acc[a]   <= '0;
            ovf[a]   <= 1'b0;
            len[a]   <= '0;
          end else begin
            phase[a] <= phase_next[a];
            acc[a]   <= acc_next[a];
            ovf[a]   <= ovf_next[a];
            len[a]   <= len_next[a];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ent.last) begin
      out_data <= res_next;
    end
  end

  a_ok_not_overlong: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.ok && out_data.overlong))
    else $error("ok together with overlong");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.ok) |->
      (out_data.value == '0 && out_data.consumed == '0 && !out_data.overflow))
    else $error("failed result carries data");

  a_suffix_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.ok && out_data.radix_kind != RK_DEC && MAX_LEN < 511)
      |-> (out_data.consumed >= CONS_W'(2)))
    else $error("suffixed match shorter than run plus suffix");

endmodule

@@ rtl/core/radix_suffix_literal_parser.sv @@
// Path: queue, then accumulators and, for a last character, the result register.
// Throughput: one character per cycle while no last character waits for the
//   result slot; set by the single accumulator step per alternative and the
//   two-entry queue between classifier and accumulators.
// Reset (rst, synchronous): clears position, queue, alternative state and the
//   result valid flag at once, not the result data; no clearing pass.
// ----------------------------------------------------------------------------
// radix_suffix_literal_parser: assembler integer literal with radix suffix
// Characters arrive one per transfer; the last carries a flag and yields one
// result: hex (h/x), octal (q/o), binary (b/y) or decimal (optional d/t).
// ----------------------------------------------------------------------------
module radix_suffix_literal_parser import rslp_pkg::*; #(
  parameter int MAX_LEN = 256  // characters looked at per string, the rest only flag overlong
) (
  input  logic          clk,
  input  logic          rst,
  rslp_stream_if.sink   chars,    // char_t: ch, last
  rslp_stream_if.source results   // result_t
);

  // Front: position count against the limit, character classification.
  qent_t f_ent;
  logic  f_valid;
  logic  f_ready;

  // Back side of the queue.
  qent_t b_ent;
  logic  b_valid;
  logic  b_ready;

  rslp_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .ent       (f_ent),
    .ent_valid (f_valid),
    .ent_ready (f_ready)
  );

  // Two entries: one transfer per cycle while the back drains, and the front
  // keeps taking characters while a finished result waits in the back.
  rslp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_ent),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (b_ent),
    .rd_valid (b_valid),
    .rd_ready (b_ready)
  );

  // Back: four accumulators, winner pick, registered result.
  rslp_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ent       (b_ent),
    .ent_valid (b_valid),
    .ent_ready (b_ready),
    .results   (results)
  );

endmodule

@@ test/radix_suffix_literal_parser_tb.sv @@
// ----------------------------------------------------------------------------
// radix_suffix_literal_parser_tb: self-checking bench for the literal parser
// Sends strings of characters into the parser and checks every result
// against a predictor kept alongside. A short table of hand-written strings
// comes first, some with the answer typed in. Random literals follow: mostly
// well-formed, some broken and some pure noise, plus one string past the
// length limit. The random part runs under four idling phases.
// ----------------------------------------------------------------------------
module radix_suffix_literal_parser_tb;
  import rslp_pkg::*;

  localparam int MAX_LEN        = 256;   // matches the parser instance below
  localparam int RANDOM_CHARS   = 160;   // characters in short random strings, all phases together
  localparam int N_PHASES       = 4;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int SETTLE_CYCLES  = 8;     // cycles waited after the drain for a stray result

  localparam int NOT_DIGIT  = -1;
  localparam int UNDERSCORE = -2;
  localparam logic [VALUE_W-1:0] ALL_ONES = '1;

  // Progress of one alternative through the string.
  typedef enum logic [1:0] {
    RUN_COLLECTING,
    RUN_MATCHED,
    RUN_FAILED
  } run_phase_e;

  typedef logic [7:0] byte_q_t [$];

  // One row of the hand-written table. want is only used where pinned is set,
  // and only on a row with last set.
  typedef struct {
    char_t   item;
    bit      pinned;
    result_t want;
  } stim_row_t;

  localparam int N_DIRECTED = 26;

  // --------------------------------------------------------------------------
  // Clock, reset and the two channels
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rslp_stream_if #(.T(char_t))   chars_if ();
  rslp_stream_if #(.T(result_t)) results_if ();

  radix_suffix_literal_parser #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .results(results_if)
  );

  // --------------------------------------------------------------------------
  // Predictor state: one accumulator per alternative, in priority order
  // (hex, octal, binary, decimal), plus the position within the string.
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] acc_val   [N_ALT];
  bit                 acc_sat   [N_ALT];
  run_phase_e         run_phase [N_ALT];
  int unsigned        run_len   [N_ALT];
  int unsigned        str_pos;
  bit                 str_overlong;

  result_t expected_results [$];

  // Bench bookkeeping
  int errors          = 0;
  int chars_sent      = 0;
  int strings_sent    = 0;
  int results_checked = 0;
  int overflow_seen   = 0;
  int overlong_seen   = 0;
  int failed_seen     = 0;
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;

  function automatic void clear_parse();
    for (int a = 0; a < N_ALT; a++) begin
      acc_val[a]   = '0;
      acc_sat[a]   = 1'b0;
      run_phase[a] = RUN_COLLECTING;
      run_len[a]   = 0;
    end
    str_pos      = 0;
    str_overlong = 1'b0;
  endfunction

  // Digit value of c in the radix of alternative alt.
  function automatic int digit_of_char(logic [1:0] alt, logic [7:0] c);
    int d;
    d = NOT_DIGIT;
    if (c == "_") return UNDERSCORE;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (alt == RK_HEX && c >= "a" && c <= "f") d = c - "a" + 10;
    else if (alt == RK_HEX && c >= "A" && c <= "F") d = c - "A" + 10;
    if (alt == RK_OCT && d > 7) return NOT_DIGIT;
    if (alt == RK_BIN && d > 1) return NOT_DIGIT;
    return d;
  endfunction

  function automatic bit is_radix_suffix(logic [1:0] alt, logic [7:0] c);
    case (alt)
      RK_HEX:  return c == "h" || c == "H" || c == "x" || c == "X";
      RK_OCT:  return c == "q" || c == "Q" || c == "o" || c == "O";
      RK_BIN:  return c == "b" || c == "B" || c == "y" || c == "Y";
      default: return c == "d" || c == "D" || c == "t" || c == "T";
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] radix_base(logic [1:0] alt);
    case (alt)
      RK_HEX:  return 64'd16;
      RK_OCT:  return 64'd8;
      RK_BIN:  return 64'd2;
      default: return 64'd10;
    endcase
  endfunction

  // One character into one alternative. Runs are greedy and never give back.
  function automatic void step_alt(logic [1:0] alt, logic [7:0] c);
    int d;
    logic [VALUE_W-1:0] base, dv;
    if (run_phase[alt] != RUN_COLLECTING) return;
    d = digit_of_char(alt, c);
    if (d == UNDERSCORE) begin
      run_len[alt]++;
    end else if (d >= 0) begin
      base = radix_base(alt);
      dv   = 64'(d);
      run_len[alt]++;
      // saturate once the next step would not fit in 64 bits
      if (acc_sat[alt] || acc_val[alt] > (ALL_ONES - dv) / base) begin
        acc_sat[alt] = 1'b1;
        acc_val[alt] = ALL_ONES;
      end else begin
        acc_val[alt] = acc_val[alt] * base + dv;
      end
    end else if (run_len[alt] == 0) begin
      run_phase[alt] = RUN_FAILED;
    end else if (is_radix_suffix(alt, c)) begin
      run_len[alt]++;
      run_phase[alt] = RUN_MATCHED;
    end else if (alt == RK_DEC) begin
      run_phase[alt] = RUN_MATCHED;   // decimal suffix is optional
    end else begin
      run_phase[alt] = RUN_FAILED;
    end
  endfunction

  // Takes one accepted character; returns 1 with the parse result on a last.
  function automatic bit parse_char(input char_t item, output result_t res);
    int win;
    win = -1;
    res = '0;
    if (str_pos >= MAX_LEN) begin
      str_overlong = 1'b1;           // characters past the limit are dropped
    end else begin
      str_pos++;
      for (int a = 0; a < N_ALT; a++) step_alt(2'(a), item.ch);
    end
    if (!item.last) return 1'b0;
    // an open decimal run matches at the end of the string
    if (run_phase[RK_DEC] == RUN_COLLECTING && run_len[RK_DEC] > 0)
      run_phase[RK_DEC] = RUN_MATCHED;
    for (int a = N_ALT - 1; a >= 0; a--)
      if (run_phase[a] == RUN_MATCHED) win = a;
    res.overlong = str_overlong;
    if (!str_overlong && win >= 0) begin
      res.ok         = 1'b1;
      res.value      = acc_val[win];
      res.radix_kind = 2'(win);
      res.consumed   = CONS_W'(run_len[win]);
      res.overflow   = acc_sat[win];
    end
    clear_parse();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sending side
  // --------------------------------------------------------------------------
  // valid stays high from one character to the next unless an idle gap is
  // drawn; either way each step sees one assignment to valid.
  task automatic push_char(input char_t item, input bit pinned, input result_t want);
    result_t predicted;
    bit      has_result;
    while ($urandom_range(99) < sender_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.data  <= item;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    // transfer done at this edge
    chars_sent++;
    has_result = parse_char(item, predicted);
    if (has_result) begin
      expected_results.push_back(pinned ? want : predicted);
      strings_sent++;
    end
  endtask

  task automatic send_string(input byte_q_t s);
    for (int i = 0; i < s.size(); i++)
      push_char('{ch: s[i], last: (i == s.size() - 1)}, 1'b0, '0);
  endtask

  function automatic logic [7:0] digit_char(logic [1:0] alt, bit maxed);
    string hex_set;
    hex_set = "0123456789abcdefABCDEF";
    case (alt)
      RK_HEX:  return maxed ? "F" : hex_set[$urandom_range(21)];
      RK_OCT:  return maxed ? "7" : 8'("0" + $urandom_range(7));
      RK_BIN:  return maxed ? "1" : 8'("0" + $urandom_range(1));
      default: return maxed ? "9" : 8'("0" + $urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] suffix_char(logic [1:0] alt);
    string sfx_set;
    case (alt)
      RK_HEX:  sfx_set = "hHxX";
      RK_OCT:  sfx_set = "qQoO";
      RK_BIN:  sfx_set = "bByY";
      default: sfx_set = "dDtT";
    endcase
    return sfx_set[$urandom_range(3)];
  endfunction

  // Noise bytes lean on characters that mean something to one of the runs.
  function automatic logic [7:0] noise_char();
    string hot_set;
    hot_set = "_0189afAFgGhHxXqQoObByYdDtTz ";
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return hot_set[$urandom_range(hot_set.len() - 1)];
  endfunction

  // One random string: mostly a literal of random radix and content, some
  // with one character spoilt, the rest noise.
  task automatic build_string(output byte_q_t s);
    int kind, len_pick, n;
    logic [1:0] alt;
    bit maxed;
    s = {};
    kind = $urandom_range(99);
    if (kind < 85) begin
      alt      = 2'($urandom_range(3));
      maxed    = ($urandom_range(9) == 0);
      len_pick = $urandom_range(99);
      // long runs now and then, so that every radix gets to overflow
      if (len_pick < 70)      n = $urandom_range(8, 1);
      else if (len_pick < 90) n = $urandom_range(24, 15);
      else if (alt == RK_BIN) n = $urandom_range(70, 60);
      else                    n = $urandom_range(40, 25);
      for (int i = 0; i < n; i++)
        s.push_back(($urandom_range(9) == 0) ? 8'("_") : digit_char(alt, maxed));
      if (alt == RK_DEC ? $urandom_range(1) : ($urandom_range(9) != 0))
        s.push_back(suffix_char(alt));
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(3, 1)) s.push_back(noise_char());
      if (kind >= 70) s[$urandom_range(s.size() - 1)] = noise_char();
    end else begin
      repeat ($urandom_range(6, 1)) s.push_back(noise_char());
    end
  endtask

  // A decimal run filling the string up to len characters, closed by a suffix.
  task automatic build_long_string(input int len, output byte_q_t s);
    s = {};
    for (int i = 0; i < len - 1; i++)
      s.push_back(($urandom_range(7) == 0) ? 8'("_") : digit_char(RK_DEC, 1'b0));
    s.push_back("d");
  endtask

  // --------------------------------------------------------------------------
  // Receiving side: random stalls, result check, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    results_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  int quiet_cycles = 0;

  always @(posedge clk) begin
    result_t want, got;
    if (!rst && results_if.valid && results_if.ready) begin
      got = results_if.data;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: %p", $time, got);
      end else begin
        want = expected_results.pop_front();
        check_field("ok",         want.ok,         got.ok);
        check_field("value",      want.value,      got.value);
        check_field("radix_kind", want.radix_kind, got.radix_kind);
        check_field("consumed",   want.consumed,   got.consumed);
        check_field("overflow",   want.overflow,   got.overflow);
        check_field("overlong",   want.overlong,   got.overlong);
        results_checked++;
        if (want.overflow) overflow_seen++;
        if (want.overlong) overlong_seen++;
        if (!want.ok)      failed_seen++;
      end
    end
    // watchdog: a long spell with no transfer on either channel means a hang
    if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_results.size());
      $display("radix_suffix_literal_parser_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Hand-written strings. Rows with pinned set carry an answer that is plain
  // from the rules; the rest go through the predictor.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [N_DIRECTED] = '{
    // no run at all: every alternative fails on the first character
    '{'{"z", 1'b1}, 1'b1, '{1'b0, 64'd0, RK_HEX, 9'd0, 1'b0, 1'b0}},
    // underscores only: an open decimal run closed by the end of the string
    '{'{"_", 1'b1}, 1'b1, '{1'b1, 64'd0, RK_DEC, 9'd1, 1'b0, 1'b0}},
    '{'{"F", 1'b0}, 1'b0, '0},
    '{'{"h", 1'b1}, 1'b1, '{1'b1, 64'd15, RK_HEX, 9'd2, 1'b0, 1'b0}},
    '{'{"7", 1'b0}, 1'b0, '0},
    '{'{"q", 1'b1}, 1'b1, '{1'b1, 64'd7, RK_OCT, 9'd2, 1'b0, 1'b0}},
    '{'{"1", 1'b0}, 1'b0, '0},
    '{'{"Y", 1'b1}, 1'b1, '{1'b1, 64'd1, RK_BIN, 9'd2, 1'b0, 1'b0}},
    '{'{"9", 1'b0}, 1'b0, '0},
    '{'{"T", 1'b1}, 1'b1, '{1'b1, 64'd9, RK_DEC, 9'd2, 1'b0, 1'b0}},
    // "10b": b is a hex digit, so binary wins over the shorter decimal match
    '{'{"1", 1'b0}, 1'b0, '0},
    '{'{"0", 1'b0}, 1'b0, '0},
    '{'{"b", 1'b1}, 1'b0, '0},
    '{'{"1", 1'b0}, 1'b0, '0},
    '{'{"2", 1'b0}, 1'b0, '0},
    '{'{"x", 1'b1}, 1'b0, '0},
    // "8o": not octal, falls back to decimal 8 with o left unparsed
    '{'{"8", 1'b0}, 1'b0, '0},
    '{'{"o", 1'b1}, 1'b0, '0},
    // suffix with nothing before it
    '{'{"h", 1'b1}, 1'b1, '{1'b0, 64'd0, RK_HEX, 9'd0, 1'b0, 1'b0}},
    '{'{"_", 1'b0}, 1'b0, '0},
    '{'{"O", 1'b1}, 1'b0, '0},
    // underscore inside the digits, then a byte from the upper half
    '{'{"3", 1'b0}, 1'b0, '0},
    '{'{"_", 1'b0}, 1'b0, '0},
    '{'{"4", 1'b0}, 1'b0, '0},
    '{'{"d", 1'b0}, 1'b0, '0},
    '{'{8'hC8, 1'b1}, 1'b0, '0}
  };

  // Idling per phase: none, sender only, receiver only, both.
  int phase_idle  [N_PHASES] = '{0, 47, 0, 13};
  int phase_stall [N_PHASES] = '{0, 0, 47, 13};

  initial begin
    byte_q_t s;
    int short_chars;
    rst              = 1'b1;
    chars_if.valid   = 1'b0;
    chars_if.data    = '0;
    clear_parse();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      push_char(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);

    short_chars = 0;
    for (int p = 0; p < N_PHASES; p++) begin
      sender_idle_pct    = phase_idle[p];
      receiver_stall_pct = phase_stall[p];
      // one string just past the limit
      if (p == 3) begin
        build_long_string(MAX_LEN + $urandom_range(6, 1), s);
        send_string(s);
      end
      while (short_chars < (p + 1) * RANDOM_CHARS / N_PHASES) begin
        build_string(s);
        send_string(s);
        short_chars += s.size();
      end
    end
    chars_if.valid <= 1'b0;

    // drain, then give a stray result time to show up
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d characters in %0d strings under four idling phases",
             chars_sent, strings_sent);
    $display("Checked %0d results: %0d saturated, %0d over length, %0d no match",
             results_checked, overflow_seen, overlong_seen, failed_seen);
    if (errors == 0)
      $display("radix_suffix_literal_parser_tb passed");
    else
      $display("radix_suffix_literal_parser_tb failed");
    $finish;
  end

endmodule
